>>> hdl/fenwick_range_sum_assert.svh
// Assertion macros for the port-level checker.
`ifndef FENWICK_RANGE_SUM_ASSERT_SVH
`define FENWICK_RANGE_SUM_ASSERT_SVH

// Checked on every clock edge outside reset.
`define FRS_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FRS_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/frs_pkg.sv
// Shared constants, types and controller interface of the Fenwick range-sum block.
package frs_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 11;
  localparam int OP_W   = 2;
  localparam int POS_W  = 10;
  localparam int IN_TDATA_W = 64;
  localparam int IN_TUSER_W = OP_W;
  localparam int OUT_TDATA_W = DATA_W;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ADD_CHK,
    ST_ADD_WR,
    ST_HI_WALK,
    ST_HI_SAVE,
    ST_LO_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clr_init;
    logic clr_write;
    logic add_init;
    logic add_rd;
    logic add_wr;
    logic walk_init_hi;
    logic walk_step;
    logic walk_init_lo;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clr_last;
    logic            add_done;
    logic            walk_done;
    logic            bad_right;
    logic            out_full;
  } stat_t;

endpackage

>>> hdl/frs_datapath.sv
// Tree store, walk index, accumulators and output register.
module frs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  frs_pkg::cmd_t                    cmd,
  output frs_pkg::stat_t                   stat,
  input  logic                             cfg_we,
  input  logic [frs_pkg::SIZE_W-1:0]       cfg_wdata,
  input  logic [frs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [frs_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [frs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tuser
);
  import frs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [SIZE_W-1:0] size_q;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  left_bound;
  logic [POS_W-1:0]  right_bound;
  logic [DATA_W-1:0] delta;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] clr_addr;
  logic [DATA_W-1:0] rd_data;
  logic              pend;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] hi;
  logic              out_valid;
  logic [DATA_W-1:0] out_sum;
  logic              out_status;

  logic [IDX_W-1:0]  n;
  logic [IDX_W-1:0]  km1;
  logic [IDX_W-1:0]  k_lo;
  logic              bad_right;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Sizes above the store depth act as the full depth.
  assign n = (size_q > SIZE_W'(DEPTH)) ? IDX_W'(DEPTH) : IDX_W'(size_q);
  assign km1 = idx - IDX_W'(1);
  // Count form of prefix(left-1), clamped to the active size.
  assign k_lo = (IDX_W'(left_bound) > n) ? n : IDX_W'(left_bound);
  assign bad_right = (IDX_W'(right_bound) >= n);

  assign rd_en   = cmd.add_rd | cmd.walk_step;
  assign rd_addr = cmd.walk_step ? km1[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign wr_en   = cmd.clr_write | cmd.add_wr;
  assign wr_addr = cmd.clr_write ? clr_addr : idx[ADDR_W-1:0];
  assign wr_data = cmd.clr_write ? '0 : rd_data + delta;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_q    <= SIZE_W'(DEPTH);
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_q <= cfg_wdata;
      end
      if (cmd.clr_init) begin
        clr_addr <= '0;
      end else if (cmd.clr_write) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      pend <= cmd.walk_step;
      if (cmd.out_write) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op          <= s_axis_tuser;
      position    <= s_axis_tdata[POS_W-1:0];
      left_bound  <= s_axis_tdata[2*POS_W-1:POS_W];
      right_bound <= s_axis_tdata[3*POS_W-1:2*POS_W];
      delta       <= s_axis_tdata[3*POS_W+DATA_W-1:3*POS_W];
    end
    if (cmd.add_init) begin
      idx <= IDX_W'(position);
    end else if (cmd.add_wr) begin
      idx <= idx | (idx + IDX_W'(1));
    end else if (cmd.walk_init_hi) begin
      idx <= IDX_W'(right_bound) + IDX_W'(1);
    end else if (cmd.walk_init_lo) begin
      idx <= k_lo;
    end else if (cmd.walk_step) begin
      idx <= km1 & idx;
    end
    // Read data lands in the cycle after its address; pend marks it.
    if (cmd.walk_init_hi || cmd.walk_init_lo) begin
      acc <= '0;
    end else if (pend) begin
      acc <= acc + rd_data;
    end
    if (cmd.walk_init_lo) begin
      hi <= acc;
    end
    if (cmd.out_write) begin
      out_sum    <= bad_right ? '0 : hi - acc;
      out_status <= bad_right;
    end
  end

  assign stat.op        = op;
  assign stat.clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.add_done  = (idx >= n);
  assign stat.walk_done = (idx == '0);
  assign stat.bad_right = bad_right;
  assign stat.out_full  = out_valid;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sum;
  assign m_axis_tuser  = out_status;

endmodule

>>> hdl/frs_ctrl.sv
// Controller state machine: sequences clears, add walks and the two prefix walks.
module frs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  frs_pkg::stat_t stat,
  output frs_pkg::cmd_t  cmd
);
  import frs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.op)
          OP_ADD:   state_next = ST_ADD_CHK;
          OP_QUERY: state_next = stat.bad_right ? ST_DONE : ST_HI_WALK;
          OP_CLEAR: state_next = ST_CLEAR;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_ADD_CHK: begin
        state_next = stat.add_done ? ST_IDLE : ST_ADD_WR;
      end
      ST_ADD_WR: begin
        state_next = ST_ADD_CHK;
      end
      ST_HI_WALK: begin
        if (stat.walk_done) state_next = ST_HI_SAVE;
      end
      ST_HI_SAVE: begin
        state_next = ST_LO_WALK;
      end
      ST_LO_WALK: begin
        if (stat.walk_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_full) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
    // A register write restarts the clearing pass.
    if (cfg_we) state_next = ST_CLEAR;
  end

  always_comb begin
    cmd = '0;
    s_axis_tready = 1'b0;
    cmd.clr_init = cfg_we;
    unique case (state) inside
      ST_CLEAR: begin
        cmd.clr_write = !cfg_we;
      end
      ST_IDLE: begin
        // no transaction in the cycle of a register write
        s_axis_tready = !cfg_we;
        cmd.load_item = s_axis_tvalid && !cfg_we;
      end
      ST_DECODE: begin
        case (stat.op)
          OP_ADD:   cmd.add_init = 1'b1;
          OP_QUERY: cmd.walk_init_hi = !stat.bad_right;
          OP_CLEAR: cmd.clr_init = 1'b1;
          default:  cmd.add_init = 1'b0;
        endcase
      end
      ST_ADD_CHK: begin
        cmd.add_rd = !stat.add_done;
      end
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
      end
      ST_HI_WALK, ST_LO_WALK: begin
        cmd.walk_step = !stat.walk_done;
      end
      ST_HI_SAVE: begin
        cmd.walk_init_lo = 1'b1;
      end
      ST_DONE: begin
        cmd.out_write = !stat.out_full;
      end
      default: cmd.clr_write = 1'b0;
    endcase
  end

endmodule

>>> hdl/fenwick_range_sum.sv
// Fenwick range-sum top level: a 1024-word tree store with add, range query and clear.
// Query: walks the high prefix, saves it, then walks the low prefix, at most 10 entries
// on each walk (none when right is out of range); ready again once the result is registered.
// Add: one read and one write per updated entry (at most 11 entries). Clear: a full clearing pass.
// Reset and every active_size write start a clearing pass over all DEPTH words; no item is taken.
module fenwick_range_sum (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [frs_pkg::SIZE_W-1:0]       cfg_wdata,      // active_size
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [frs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // position, left_bound, right_bound, delta, zero pad
  input  logic [frs_pkg::IN_TUSER_W-1:0]   s_axis_tuser,   // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [frs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // range_sum
  output logic                             m_axis_tuser    // status
);
  import frs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  frs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  frs_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> hdl/frs_checker.sv
// Port-level checks on the Fenwick range-sum block, bound to the top level.
`include "fenwick_range_sum_assert.svh"

module frs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic [frs_pkg::SIZE_W-1:0]       cfg_wdata,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [frs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic [frs_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [frs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);

  `FRS_CHECK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `FRS_CHECK(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `FRS_CHECK(a_bad_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "out-of-range query with nonzero sum")
  `FRS_CHECK_ALWAYS(a_rst_clear, rst |=> !s_axis_tready && !m_axis_tvalid, "input taken or result shown during reset clear")
  `FRS_CHECK(a_one_at_time, (s_axis_tvalid && s_axis_tready) || cfg_we |=> !s_axis_tready, "ready right after a transaction or register write")

endmodule

bind fenwick_range_sum frs_checker u_frs_checker (.*);

>>> tb/range_sum_checker.sv
// Checker for the Fenwick range-sum block: tracks the tree, predicts query sums, compares.
`timescale 1ns / 1ps

module range_sum_checker
  import frs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [SIZE_W-1:0]      cfg_wdata,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [DATA_W-1:0] total;
    logic              status;
  } query_answer_t;

  logic [DATA_W-1:0] tree_words [DEPTH];
  int unsigned       size_now;
  query_answer_t     answers_due [$];

  function automatic int unsigned span();
    return (size_now > DEPTH) ? DEPTH : size_now;
  endfunction

  function automatic void wipe_tree();
    for (int i = 0; i < DEPTH; i++) tree_words[i] = '0;
  endfunction

  // Sum of positions 0..upto; walks k-1, then (k-1)&k down to zero.
  function automatic logic [DATA_W-1:0] prefix_total(input int unsigned upto);
    logic [DATA_W-1:0] acc;
    int unsigned       k;
    acc = '0;
    k   = upto + 1;
    while (k > 0) begin
      acc += tree_words[k-1];
      k = (k - 1) & k;
    end
    return acc;
  endfunction

  function automatic void add_delta(input int unsigned pos, input logic [DATA_W-1:0] delta);
    int unsigned i;
    i = pos;
    while (i < span()) begin
      tree_words[i] += delta;
      i = i | (i + 1);
    end
  endfunction

  function automatic query_answer_t range_total(input int unsigned left,
                                                input int unsigned right);
    query_answer_t ans;
    int unsigned   n, j;
    logic [DATA_W-1:0] lo;
    n   = span();
    ans = '0;
    if (right >= n) begin
      ans.status = 1'b1;
    end else begin
      lo = '0;
      if (left > 0) begin
        j = left - 1;
        // left past the size clamps to the top of the tree
        if (j >= n) j = n - 1;
        lo = prefix_total(j);
      end
      ans.total = prefix_total(right) - lo;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    query_answer_t due;
    if (rst) begin
      wipe_tree();
      size_now = DEPTH;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        size_now = 32'(cfg_wdata);
        wipe_tree();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          $error("range_sum: no query pending, got %0d status %0b",
                 $signed(m_axis_tdata), m_axis_tuser);
          fail_count++;
        end else begin
          due = answers_due.pop_front();
          if (m_axis_tdata !== due.total) begin
            $error("range_sum: expected %0d, actual %0d",
                   $signed(due.total), $signed(m_axis_tdata));
            fail_count++;
          end
          if (m_axis_tuser !== due.status) begin
            $error("status: expected %0b, actual %0b", due.status, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_ADD:   add_delta(32'(s_axis_tdata[9:0]), s_axis_tdata[61:30]);
          OP_QUERY: answers_due.push_back(range_total(32'(s_axis_tdata[19:10]),
                                                      32'(s_axis_tdata[29:20])));
          OP_CLEAR: wipe_tree();
          default:  ;
        endcase
      end
    end
    pending = answers_due.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the Fenwick range-sum testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import frs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 1100;  // covers a clear or a clearing pass
  localparam int HOLD_CYCLES   = 600;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [SIZE_W-1:0]      cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int          fail_count;
  int          pending;
  int unsigned cur_size;
  int          send_gap_max;
  int          recv_gap_max;
  bit          hold_req;

  fenwick_range_sum u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  range_sum_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always #10 clk = ~clk;

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer(input logic [OP_W-1:0] op, input logic [9:0] pos,
                       input logic [9:0] left, input logic [9:0] right,
                       input logic [31:0] delta);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, delta, right, left, pos};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic random_item();
    int unsigned lim, sel;
    logic [OP_W-1:0] op;
    logic [9:0]  pos, left, right;
    logic [31:0] delta;
    lim   = (cur_size > DEPTH) ? DEPTH : cur_size;
    pos   = 10'($urandom);
    left  = 10'($urandom);
    right = 10'($urandom);
    delta = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 46)      op = OP_ADD;
    else if (sel < 95) op = OP_QUERY;
    else if (sel < 97) op = OP_CLEAR;
    else               op = OP_UNUSED;
    // keep most indexes inside the tree so adds and queries do real work
    if (lim > 0 && $urandom_range(0, 9) < 8) pos = 10'($urandom_range(0, lim - 1));
    if (lim > 0 && $urandom_range(0, 9) < 8) begin
      right = 10'($urandom_range(0, lim - 1));
      sel = $urandom_range(0, 9);
      if (sel < 7)       left = 10'($urandom_range(0, 32'(right)));
      else if (sel == 7) left = '0;
    end
    sel = $urandom_range(0, 9);
    if (sel >= 5 && sel < 8) delta = $urandom_range(0, 200) - 100;
    else if (sel >= 8) begin
      case ($urandom_range(0, 3))
        0:       delta = 32'h7FFF_FFFF;
        1:       delta = 32'h8000_0000;
        2:       delta = 32'hFFFF_FFFF;
        default: delta = 32'h0000_0000;
      endcase
    end
    offer(op, pos, left, right, delta);
  endtask

  task automatic run_random(input int count);
    repeat (count) random_item();
  endtask

  // Let the block drain before touching the size register.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_size(input int unsigned value);
    cfg_wdata <= value[SIZE_W-1:0];
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_size  = value;
  endtask

  // Output side: random stall per result, long hold on request.
  initial begin
    int n;
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      n = $urandom_range(0, recv_gap_max);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_req      = 1'b0;
    send_gap_max  = 7;
    recv_gap_max  = 7;
    cur_size      = DEPTH;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    settle();

    // full-size tree: extremes, reversed bounds, unused op, clear
    offer(OP_ADD,    10'd0,    10'd0,    10'd0,    32'h7FFF_FFFF);
    offer(OP_ADD,    10'd1023, 10'd0,    10'd0,    32'h8000_0000);
    offer(OP_ADD,    10'd511,  10'd0,    10'd0,    32'hFFFF_FFFF);
    offer(OP_ADD,    10'd700,  10'd0,    10'd0,    32'd12345);
    offer(OP_QUERY,  10'd0,    10'd0,    10'd1023, 32'd0);
    offer(OP_QUERY,  10'd0,    10'd0,    10'd0,    32'd0);
    offer(OP_QUERY,  10'd0,    10'd1023, 10'd1023, 32'd0);
    offer(OP_QUERY,  10'd0,    10'd1,    10'd1023, 32'd0);
    offer(OP_QUERY,  10'd0,    10'd600,  10'd10,   32'd0);
    offer(OP_QUERY,  10'd0,    10'd1023, 10'd0,    32'd0);
    offer(OP_UNUSED, 10'd1023, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    offer(OP_QUERY,  10'd1023, 10'd0,    10'd1023, 32'hFFFF_FFFF);
    offer(OP_CLEAR,  10'd0,    10'd0,    10'd0,    32'd0);
    offer(OP_QUERY,  10'd0,    10'd0,    10'd1023, 32'd0);
    offer(OP_ADD,    10'd2,    10'd0,    10'd0,    32'd7);
    offer(OP_QUERY,  10'd0,    10'd2,    10'd2,    32'd0);
    run_random(110);

    // small tree: adds and bounds past the size
    settle();
    write_size(17);
    offer(OP_ADD,   10'd20, 10'd0,  10'd0,  32'd5);
    offer(OP_ADD,   10'd16, 10'd0,  10'd0,  32'd9);
    offer(OP_QUERY, 10'd0,  10'd0,  10'd30, 32'd0);
    offer(OP_QUERY, 10'd0,  10'd25, 10'd16, 32'd0);
    offer(OP_QUERY, 10'd0,  10'd0,  10'd16, 32'd0);
    offer(OP_QUERY, 10'd0,  10'd17, 10'd16, 32'd0);
    run_random(80);

    settle();
    write_size(1);
    run_random(40);

    // zero size: every query reports the bound error
    settle();
    write_size(0);
    run_random(30);

    // size above the store acts as the full store; long output hold, then drain pause
    settle();
    write_size(2047);
    hold_req = 1'b1;
    repeat (30) offer(OP_QUERY, 10'($urandom), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)), $urandom);
    run_random(50);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    run_random(70);

    // back-to-back stretch with no idling on either side
    settle();
    write_size(300);
    send_gap_max = 0;
    recv_gap_max = 0;
    run_random(120);

    settle();
    write_size(DEPTH);
    send_gap_max = 7;
    recv_gap_max = 7;
    run_random(170);

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
